[hw/rtl/bprn_pkg.sv]
package bprn_pkg;

    // sample and coefficient widths
    localparam int SAMPLE_W    = 16;
    localparam int TARGET_W    = 15;
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

    // accumulator, mean and root widths
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int SUM_W  = SQ_W + ADDR_W - 1;
    localparam int MEAN_W = SQ_W;
    localparam int ROOT_W = MEAN_W / 2;

    // product of a sample and the target peak
    localparam int PROD_W = SAMPLE_W + TARGET_W + 1;

    // shared divider
    localparam int DIV_W       = SUM_W;
    localparam int DIVISOR_W   = SAMPLE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int ROOT_CNT_W  = $clog2(ROOT_W + 1);

    localparam logic [TARGET_W-1:0] TARGET_RESET = {TARGET_W{1'b1}};

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

[hw/rtl/bprn_divider.sv]
module bprn_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic [bprn_pkg::DIV_W-1:0]     dividend,
    input  logic [bprn_pkg::DIVISOR_W-1:0] divisor,
    output logic [bprn_pkg::DIV_W-1:0]     quotient,
    output bprn_pkg::unit_status_t         status
);
    import bprn_pkg::*;

    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // sequencing of the steps
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = dvd_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/bprn_isqrt.sv]
module bprn_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [bprn_pkg::MEAN_W-1:0] radicand,
    output logic [bprn_pkg::ROOT_W-1:0] root,
    output bprn_pkg::unit_status_t      status
);
    import bprn_pkg::*;

    logic [MEAN_W-1:0]     x_reg, x_next;
    logic [MEAN_W-1:0]     res_reg, res_next;
    logic [MEAN_W-1:0]     bit_reg, bit_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [MEAN_W:0]       trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    // one root digit per cycle, bit walks down two places a step
    always_comb
    begin
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            x_next   = radicand;
            res_next = '0;
            bit_next = MEAN_W'(1) << (MEAN_W - 2);
            cnt_next = ROOT_CNT_W'(ROOT_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if ({1'b0, x_reg} >= trial)
            begin
                x_next   = x_reg - trial[MEAN_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ROOT_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root        = res_reg[ROOT_W-1:0];
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

[hw/rtl/block_peak_rms_normalizer.sv]
// channel   direction  handshake                     word
// input     in         start, accepted when !busy    sample_in, block_last
// result    out        result_valid, one-cycle strobe scaled_sample, peak_level,
//                                                    rms_level, out_last
// config    in         cfg_valid / cfg_ready         target_peak
//
// loading a sample writes the store, then updates the peak and square sum
// the item marked last adds a mean divide (37 divider steps) and a root (16 steps),
// then each stored sample is read, multiplied and scaled by 37 steps of the shared
// divider and its done cycle
// a silent block skips the scaling divide and emits each sample from the multiply state
// rst_n is asynchronous; all accumulators clear, target_peak returns to full scale
// results are strobed for one cycle and cannot be held off; busy is low on the last word
module block_peak_rms_normalizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bprn_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                          block_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bprn_pkg::TARGET_W-1:0] target_peak,
    output logic                          result_valid,
    output logic [bprn_pkg::SAMPLE_W-1:0] scaled_sample,
    output logic [bprn_pkg::SAMPLE_W-1:0] peak_level,
    output logic [bprn_pkg::ROOT_W-1:0]   rms_level,
    output logic                          out_last
);
    import bprn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MEAN,
        S_MEAN_WAIT,
        S_ROOT_WAIT,
        S_READ,
        S_MUL,
        S_SCALE_WAIT
    } state_t;

    localparam logic [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    state_t               state_reg, state_next;
    logic [TARGET_W-1:0]  target_reg, target_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 last_reg, last_next;
    logic                 keep_reg, keep_next;
    logic [SAMPLE_W-1:0]  peak_reg, peak_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [ROOT_W-1:0]    rms_reg, rms_next;
    logic                 neg_reg, neg_next;
    logic                 valid_reg, valid_next;
    logic [SAMPLE_W-1:0]  scaled_reg, scaled_next;
    logic                 out_last_reg, out_last_next;

    logic [SAMPLE_W-1:0]  store [MAX_SAMPLES];
    logic [SAMPLE_W-1:0]  rd_data_reg;

    logic                 accept;
    logic [SAMPLE_W-1:0]  mag;
    logic [SQ_W-1:0]      square;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]    prod_abs;
    logic                 is_last_idx;
    logic [SAMPLE_W-1:0]  scaled_div;

    logic                 div_go;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [DIV_W-1:0]     div_quot;
    unit_status_t         div_status;

    logic                 root_go;
    logic [ROOT_W-1:0]    root_val;
    unit_status_t         root_status;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // sample store, written while loading and read during the output pass
    always_ff @(posedge clk)
    begin
        if (accept && (count_reg < COUNT_W'(MAX_SAMPLES)))
        begin
            store[count_reg[ADDR_W-1:0]] <= sample_in;
        end
        rd_data_reg <= store[idx_reg];
    end

    // magnitude and square of the held sample
    always_comb
    begin
        mag    = sample_reg[SAMPLE_W-1] ? (~sample_reg + 1'b1) : sample_reg;
        square = mag * mag;
    end

    // scaling product and its magnitude
    always_comb
    begin
        prod     = $signed(rd_data_reg) * $signed({1'b0, target_reg});
        prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    end

    // saturate the divider quotient back to the sample range
    always_comb
    begin
        if (!neg_reg)
        begin
            if (|div_quot[DIV_W-1:SAMPLE_W-1])
                scaled_div = SMAX;
            else
                scaled_div = div_quot[SAMPLE_W-1:0];
        end
        else
        begin
            if ((|div_quot[DIV_W-1:SAMPLE_W])
                || (div_quot[SAMPLE_W-1] && (|div_quot[SAMPLE_W-2:0])))
                scaled_div = SMIN;
            else
                scaled_div = ~div_quot[SAMPLE_W-1:0] + 1'b1;
        end
    end

    assign is_last_idx = ({1'b0, idx_reg} == (count_reg - 1'b1));

    // shared divider operands: mean of squares, or product over peak
    always_comb
    begin
        div_go       = 1'b0;
        div_dividend = DIV_W'(prod_abs);
        div_divisor  = peak_reg;
        if (state_reg == S_MEAN)
        begin
            div_go       = 1'b1;
            div_dividend = sum_reg;
            div_divisor  = DIVISOR_W'(count_reg);
        end
        else if ((state_reg == S_MUL) && (peak_reg != '0))
        begin
            div_go = 1'b1;
        end
    end

    assign root_go = (state_reg == S_MEAN_WAIT) && div_status.done;

    bprn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    bprn_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (root_go),
        .radicand (div_quot[MEAN_W-1:0]),
        .root     (root_val),
        .status   (root_status)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        target_next   = target_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        keep_next     = keep_reg;
        peak_next     = peak_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rms_next      = rms_reg;
        neg_next      = neg_reg;
        valid_next    = 1'b0;
        scaled_next   = scaled_reg;
        out_last_next = 1'b0;

        if (cfg_valid)
            target_next = target_peak;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sample_next = sample_in;
                    last_next   = block_last;
                    keep_next   = (count_reg < COUNT_W'(MAX_SAMPLES));
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                if (keep_reg)
                begin
                    if (mag > peak_reg)
                        peak_next = mag;
                    sum_next   = sum_reg + SUM_W'(square);
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? S_MEAN : S_IDLE;
            end
            S_MEAN:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_status.done)
                    state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (root_status.done)
                begin
                    rms_next   = root_val;
                    idx_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                neg_next = prod[PROD_W-1];
                if (peak_reg == '0)
                begin
                    // silent block passes samples through
                    scaled_next   = rd_data_reg;
                    valid_next    = 1'b1;
                    out_last_next = is_last_idx;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = is_last_idx ? S_IDLE : S_READ;
                end
                else
                begin
                    state_next = S_SCALE_WAIT;
                end
            end
            S_SCALE_WAIT:
            begin
                if (div_status.done)
                begin
                    scaled_next   = scaled_div;
                    valid_next    = 1'b1;
                    out_last_next = is_last_idx;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = is_last_idx ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // block emitted: clear accumulators for the next one
        if (out_last_next)
        begin
            peak_next  = '0;
            sum_next   = '0;
            count_next = '0;
        end
    end

    // state, accumulators and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            target_reg   <= TARGET_RESET;
            sample_reg   <= '0;
            last_reg     <= 1'b0;
            keep_reg     <= 1'b0;
            peak_reg     <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            rms_reg      <= '0;
            neg_reg      <= 1'b0;
            valid_reg    <= 1'b0;
            scaled_reg   <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            target_reg   <= target_next;
            sample_reg   <= sample_next;
            last_reg     <= last_next;
            keep_reg     <= keep_next;
            peak_reg     <= peak_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rms_reg      <= rms_next;
            neg_reg      <= neg_next;
            valid_reg    <= valid_next;
            scaled_reg   <= scaled_next;
            out_last_reg <= out_last_next;
        end
    end

    // the peak is cleared with the last word, so the emitted copy comes from a holding reg
    logic [SAMPLE_W-1:0] peak_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_out_reg <= '0;
        else if (valid_next)
            peak_out_reg <= peak_reg;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = valid_reg;
    assign scaled_sample = scaled_reg;
    assign peak_level    = peak_out_reg;
    assign rms_level     = rms_reg;
    assign out_last      = out_last_reg;

endmodule

[hw/rtl/bprn_checker.sv]
module bprn_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic out_last
);
    import bprn_pkg::*;

    // an accepted word always occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // words before the last one of a block arrive while busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_last |-> busy)
        else $error("non-final word while idle");

    // the last word of a block frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_last |-> !busy)
        else $error("final word while still busy");

    // no result appears out of a block that was already idle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !result_valid)
        else $error("result word without work");

endmodule

bind block_peak_rms_normalizer bprn_checker u_bprn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .out_last     (out_last)
);

[tb/block_peak_rms_normalizer_tb.sv]
module block_peak_rms_normalizer_tb;

    import bprn_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_PAUSE = 60;
    localparam int MAX_REPORTS = 10;

    // one input word and one normalized output word
    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        logic                lst;
    } sample_word_t;

    typedef struct {
        logic [SAMPLE_W-1:0] scaled;
        logic [SAMPLE_W-1:0] peak;
        logic [ROOT_W-1:0]   rms;
        logic                lst;
    } norm_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] sample_in = '0;
    logic                block_last = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TARGET_W-1:0] target_peak = TARGET_RESET;
    logic                result_valid;
    logic [SAMPLE_W-1:0] scaled_sample;
    logic [SAMPLE_W-1:0] peak_level;
    logic [ROOT_W-1:0]   rms_level;
    logic                out_last;

    sample_word_t sample_q[$];
    norm_word_t   scaled_q[$];
    norm_word_t   scaled_head;
    int           send_idle_pct = 0;
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;

    // predictor state: the block being loaded and the current target
    logic [SAMPLE_W-1:0] blk_store[MAX_SAMPLES];
    longint              blk_peak = 0;
    longint              blk_sum = 0;
    int                  blk_count = 0;
    longint              tgt_cur = longint'(TARGET_RESET);

    block_peak_rms_normalizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample_in     (sample_in),
        .block_last    (block_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .target_peak   (target_peak),
        .result_valid  (result_valid),
        .scaled_sample (scaled_sample),
        .peak_level    (peak_level),
        .rms_level     (rms_level),
        .out_last      (out_last)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // floor of the square root, bit by bit from the top
    function automatic longint floor_sqrt(input longint x);
        longint root;
        longint cand;
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    // load one sample; on the last one emit the scaled block and clear
    task automatic norm_block_accept(input logic [SAMPLE_W-1:0] smp, input logic lst);
        longint     s;
        longint     mag;
        longint     v;
        longint     r;
        longint     root;
        norm_word_t w;
        s = longint'($signed(smp));
        // samples beyond a full store are dropped
        if (blk_count < MAX_SAMPLES)
        begin
            mag = (s < 0) ? -s : s;
            blk_store[blk_count] = smp;
            if (mag > blk_peak)
                blk_peak = mag;
            blk_sum += mag * mag;
            blk_count++;
        end
        if (!lst)
            return;
        root = floor_sqrt(blk_sum / blk_count);
        for (int i = 0; i < blk_count; i++)
        begin
            v = longint'($signed(blk_store[i]));
            // silent block passes through unchanged
            if (blk_peak == 0)
                r = v;
            else
            begin
                r = (v * tgt_cur) / blk_peak;
                if (r > 32767)
                    r = 32767;
                if (r < -32768)
                    r = -32768;
            end
            w.scaled = r[SAMPLE_W-1:0];
            w.peak   = blk_peak[SAMPLE_W-1:0];
            w.rms    = root[ROOT_W-1:0];
            w.lst    = (i == blk_count - 1);
            scaled_q.push_back(w);
        end
        blk_peak  = 0;
        blk_sum   = 0;
        blk_count = 0;
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    // sample generator weighted toward the extremes
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int tmp;
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3:
            begin
                tmp = int'($urandom_range(8)) - 4;
                return tmp[SAMPLE_W-1:0];
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
        sample_word_t sw;
        sw.smp = smp;
        sw.lst = lst;
        sample_q.push_back(sw);
    endtask

    task automatic queue_block(input int len, input bit silent);
        for (int i = 0; i < len; i++)
            queue_word(silent ? '0 : rand_sample(), i == len - 1);
    endtask

    // wait until every word is sent, every result is back and the block is idle
    task automatic drain();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || start || busy || scaled_q.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // write the target register over its own channel
    task automatic write_target(input logic [TARGET_W-1:0] val);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        target_peak <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tgt_cur = longint'(val);
    endtask

    // random blocks, mostly short, some silent
    task automatic random_phase(input logic [TARGET_W-1:0] val, input int idle_pct,
                                input int n_items, input int long_len);
        int cnt;
        int len;
        write_target(val);
        send_idle_pct = idle_pct;
        @(negedge clk);
        cnt = 0;
        if (long_len > 0)
        begin
            queue_block(long_len, 1'b0);
        end
        while (cnt < n_items)
        begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 9))
                                           : int'($urandom_range(8, 1));
            queue_block(len, $urandom_range(7) == 0);
            cnt += len;
        end
        drain();
    endtask

    // driver: next word goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            sample_in  <= '0;
            block_last <= 1'b0;
        end
        else if (!start || !busy)
        begin
            if (sample_q.size() != 0 && int'($urandom_range(99)) >= send_idle_pct)
            begin
                start      <= 1'b1;
                sample_in  <= sample_q[0].smp;
                block_last <= sample_q[0].lst;
                void'(sample_q.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // accepted words feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            norm_block_accept(sample_in, block_last);
    end

    // monitor: compare each strobed word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (scaled_q.size() == 0)
                note_mismatch($sformatf("unexpected word scaled=%0d peak=%0d rms=%0d last=%0b",
                    $signed(scaled_sample), peak_level, rms_level, out_last));
            else
            begin
                scaled_head = scaled_q.pop_front();
                if (scaled_sample !== scaled_head.scaled || peak_level !== scaled_head.peak ||
                    rms_level !== scaled_head.rms || out_last !== scaled_head.lst)
                    note_mismatch($sformatf(
                        "exp scaled=%0d peak=%0d rms=%0d last=%0b, got %0d %0d %0d %0b",
                        $signed(scaled_head.scaled), scaled_head.peak, scaled_head.rms,
                        scaled_head.lst, $signed(scaled_sample), peak_level, rms_level,
                        out_last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        @(negedge clk);

        // directed blocks at the reset target
        queue_word(16'h7fff, 1'b1);
        queue_word(16'h8000, 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h0000, 1'b1);
        queue_word(16'h0001, 1'b0);
        queue_word(16'hffff, 1'b0);
        queue_word(16'h4000, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h7fff, 1'b1);
        queue_word(16'd100, 1'b0);
        queue_word(-16'sd50, 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h0005, 1'b1);
        queue_word(16'hffff, 1'b1);
        queue_word(16'h5555, 1'b0);
        queue_word(16'haaaa, 1'b1);
        drain();

        // target extremes, then a random one; one block overruns the store
        random_phase('0, 36, 34, 0);
        random_phase(15'd1, 76, 34, 66);
        random_phase(TARGET_RESET, 0, 34, 0);
        random_phase(TARGET_W'($urandom_range(32767)), 0, 34, 0);

        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
